// ----- rtl/core/button_click_classifier_core_defines.svh -----
// ----------------------------------------------------------------------------
// Button click classifier: assertion macros
// Shared helpers for the concurrent checks on the core's ports.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_CLASSIFIER_CORE_DEFINES_SVH
`define BUTTON_CLICK_CLASSIFIER_CORE_DEFINES_SVH

// Check sampled on clk, masked while rst_n is low.
`define BCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check sampled on clk, live during reset too.
`define BCC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/bcc_pkg.sv -----
// ----------------------------------------------------------------------------
// Button click classifier: package
// Phase, edge, event and register codes shared by the core modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_RELEASED = 2'd2
    } phase_t;

    // edge request codes
    localparam logic [1:0] EDGE_NONE    = 2'd0;
    localparam logic [1:0] EDGE_PRESS   = 2'd1;
    localparam logic [1:0] EDGE_RELEASE = 2'd2;

    // event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_SHORT = 2'd1;
    localparam logic [1:0] EV_MULTI = 2'd2;
    localparam logic [1:0] EV_LONG  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_HOLD_LIMIT = 2'd0;
    localparam logic [1:0] CFG_GAP_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_CEILING    = 2'd2;

    localparam int unsigned CFG_BITS = 16;
    localparam logic [CFG_BITS-1:0] HOLD_LIMIT_RESET = 16'd100;
    localparam logic [CFG_BITS-1:0] GAP_LIMIT_RESET  = 16'd30;
    localparam logic [CFG_BITS-1:0] CEILING_RESET    = 16'd200;

    localparam int unsigned IN_DATA_BITS  = 8;
    localparam int unsigned OUT_DATA_BITS = 16;
    localparam int unsigned OUT_USED_BITS = 10;

    // single-bit and code state of the classifier
    typedef struct packed {
        phase_t     phase;
        logic       check_armed;
        logic       event_pending;
        logic       was_long;
        logic [1:0] event_kind;
    } flags_t;

    // one result word: event code, click count
    typedef struct packed {
        logic [7:0] click_count;
        logic [1:0] event_code;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/bcc_step.sv -----
// ----------------------------------------------------------------------------
// Button click classifier: tick logic
// Next state and result for one tick, applied in edge / phase / report order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcc_step #(
    parameter int TIMER_BITS = 16,
    parameter int COUNT_BITS = 8
) (
    input  wire logic [1:0]                      edge_req,
    input  wire bcc_pkg::flags_t                 flags_in,
    input  wire logic [TIMER_BITS-1:0]           hold_in,
    input  wire logic [TIMER_BITS-1:0]           gap_in,
    input  wire logic [COUNT_BITS-1:0]           count_in,
    input  wire logic [bcc_pkg::CFG_BITS-1:0]    hold_limit,
    input  wire logic [bcc_pkg::CFG_BITS-1:0]    gap_limit,
    input  wire logic [TIMER_BITS-1:0]           ceiling,
    output bcc_pkg::flags_t                      flags_out,
    output logic [TIMER_BITS-1:0]                hold_out,
    output logic [TIMER_BITS-1:0]                gap_out,
    output logic [COUNT_BITS-1:0]                count_out,
    output bcc_pkg::result_t                     result
);
    import bcc_pkg::*;

    localparam int CW = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
    localparam int KW = (COUNT_BITS > 8) ? COUNT_BITS : 8;

    flags_t                 f;
    logic [TIMER_BITS-1:0]  hold;
    logic [TIMER_BITS-1:0]  gap;
    logic [COUNT_BITS-1:0]  pc;
    logic [KW-1:0]          pc_k;

    always_comb
    begin
        f    = flags_in;
        hold = hold_in;
        gap  = gap_in;
        pc   = count_in;
        result.event_code  = EV_NONE;
        result.click_count = 8'd1;
        pc_k = '0;

        // edge sets phase, arms the check, zeroes that phase's timer
        case (edge_req)
            EDGE_PRESS:
            begin
                f.phase       = PH_PRESSED;
                f.check_armed = 1'b1;
                hold          = '0;
            end
            EDGE_RELEASE:
            begin
                f.phase       = PH_RELEASED;
                f.check_armed = 1'b1;
                gap           = '0;
            end
            default: ;
        endcase

        case (f.phase)
            PH_PRESSED:
            begin
                if (hold < ceiling)
                    hold = hold + TIMER_BITS'(1);
                if (CW'(hold) > CW'(hold_limit))
                begin
                    if (f.event_kind != EV_NONE)
                    begin
                        // flush the pending click before the long press
                        if (pc > COUNT_BITS'(1))
                            pc = pc - COUNT_BITS'(1);
                        f.event_pending = 1'b1;
                    end
                    else
                    begin
                        f.was_long      = 1'b1;
                        f.phase         = PH_IDLE;
                        f.event_kind    = EV_LONG;
                        f.event_pending = 1'b1;
                        pc              = COUNT_BITS'(1);
                        gap             = ceiling;
                    end
                end
                if (f.check_armed)
                begin
                    f.check_armed = 1'b0;
                    if (!f.was_long)
                    begin
                        if (CW'(gap) < CW'(gap_limit))
                        begin
                            if (pc != {COUNT_BITS{1'b1}})
                                pc = pc + COUNT_BITS'(1);
                        end
                        else
                            pc = COUNT_BITS'(1);
                    end
                    f.was_long = 1'b0;
                end
            end
            PH_RELEASED:
            begin
                if (gap < ceiling)
                    gap = gap + TIMER_BITS'(1);
                if (f.check_armed)
                begin
                    f.check_armed = 1'b0;
                    if (!f.was_long)
                    begin
                        if (pc > COUNT_BITS'(1))
                            f.event_kind = EV_MULTI;
                        else
                        begin
                            f.event_kind = EV_SHORT;
                            pc           = COUNT_BITS'(1);
                        end
                    end
                end
                if ((CW'(gap) > CW'(gap_limit)) && !f.was_long)
                begin
                    f.event_pending = 1'b1;
                    f.phase         = PH_IDLE;
                end
            end
            default: ;
        endcase

        // report and clear
        if (f.event_pending)
        begin
            f.event_pending   = 1'b0;
            result.event_code = f.event_kind;
            if (f.event_kind == EV_MULTI)
            begin
                pc_k = KW'(pc);
                result.click_count = (pc_k > KW'(8'hFF)) ? 8'hFF : pc_k[7:0];
            end
            f.event_kind = EV_NONE;
        end

        flags_out = f;
        hold_out  = hold;
        gap_out   = gap;
        count_out = pc;
    end

endmodule

`default_nettype wire

// ----- rtl/core/bcc_out_buf.sv -----
// ----------------------------------------------------------------------------
// Button click classifier: output register with skid stage
// Holds result words so the input side can take one more word under a stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcc_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire bcc_pkg::result_t  in_word,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output bcc_pkg::result_t       out_word
);
    import bcc_pkg::*;

    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    take;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;
    assign take      = in_valid && !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg  <= skid_valid_reg || take;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
            out_reg <= skid_valid_reg ? skid_reg : in_word;
        else if (take)
            skid_reg <= in_word;
    end

endmodule

`default_nettype wire

// ----- rtl/core/button_click_classifier_core.sv -----
// ----------------------------------------------------------------------------
// Button click classifier core
// Tick-driven short / multi-click / long-press classifier for one key.
// ----------------------------------------------------------------------------
//
//  channel   direction  signals                            word
//  --------  ---------  ---------------------------------  -------------------------
//  s_axis    in         tvalid tready tdata[7:0]           [1:0] edge_req
//  m_axis    out        tvalid tready tdata[15:0]          [1:0] event_code,
//                                                          [9:2] click_count
//  cfg       in         valid ready index[1:0] data[15:0]  hold/gap limit, ceiling
//
//  One input word (one tick) is taken per clock while s_axis_tready is high;
//  every tick yields exactly one result word, registered in the output buffer.
//  The tick logic is a single combinational pass from the state registers;
//  throughput is bounded only by the two-entry output buffer.
//  Reset loads the classifier and config registers at once; no clearing pass,
//  the core is ready as soon as rst_n rises.
//  Under m_axis stall one more word goes into the skid stage, then
//  s_axis_tready drops until the output drains.
//  cfg_ready is always high; writes are expected while the core is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module button_click_classifier_core #(
    parameter int TIMER_BITS = 16,
    parameter int COUNT_BITS = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // input words: [1:0] edge_req, rest zero
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [bcc_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    // result words: [1:0] event_code, [9:2] click_count, rest zero
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [bcc_pkg::OUT_DATA_BITS-1:0]        m_axis_tdata,
    // register writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [1:0]                          cfg_index,
    input  wire logic [bcc_pkg::CFG_BITS-1:0]        cfg_data
);
    import bcc_pkg::*;

    localparam int CW = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
    // largest timer value the counters can hold
    localparam logic [CW-1:0] TMAX = CW'({TIMER_BITS{1'b1}});
    localparam logic [CW-1:0] CEIL_RST_W =
        (CW'(CEILING_RESET) > TMAX) ? TMAX : CW'(CEILING_RESET);
    localparam logic [TIMER_BITS-1:0] GAP_RESET = CEIL_RST_W[TIMER_BITS-1:0];

    // configuration
    logic [CFG_BITS-1:0] hold_limit_reg;
    logic [CFG_BITS-1:0] gap_limit_reg;
    logic [CFG_BITS-1:0] ceiling_reg;

    // classifier state
    flags_t                 flags_reg;
    logic [TIMER_BITS-1:0]  hold_reg;
    logic [TIMER_BITS-1:0]  gap_reg;
    logic [COUNT_BITS-1:0]  count_reg;

    flags_t                 flags_next;
    logic [TIMER_BITS-1:0]  hold_next;
    logic [TIMER_BITS-1:0]  gap_next;
    logic [COUNT_BITS-1:0]  count_next;
    result_t                result;
    result_t                out_word;

    logic [CW-1:0]          ceil_w;
    logic [TIMER_BITS-1:0]  ceiling;
    logic                   tick;

    assign cfg_ready = 1'b1;
    assign tick      = s_axis_tvalid && s_axis_tready;

    // ceiling in use: register clipped to the timer width
    assign ceil_w  = (CW'(ceiling_reg) > TMAX) ? TMAX : CW'(ceiling_reg);
    assign ceiling = ceil_w[TIMER_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_limit_reg <= HOLD_LIMIT_RESET;
            gap_limit_reg  <= GAP_LIMIT_RESET;
            ceiling_reg    <= CEILING_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_HOLD_LIMIT: hold_limit_reg <= cfg_data;
                CFG_GAP_LIMIT:  gap_limit_reg  <= cfg_data;
                CFG_CEILING:    ceiling_reg    <= cfg_data;
                default: ;      // unmapped index, dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '{phase: PH_IDLE, check_armed: 1'b0, event_pending: 1'b0,
                           was_long: 1'b0, event_kind: EV_NONE};
            hold_reg  <= '0;
            gap_reg   <= GAP_RESET;
            count_reg <= COUNT_BITS'(1);
        end
        else if (tick)
        begin
            flags_reg <= flags_next;
            hold_reg  <= hold_next;
            gap_reg   <= gap_next;
            count_reg <= count_next;
        end
    end

    bcc_step #(
        .TIMER_BITS (TIMER_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .edge_req   (s_axis_tdata[1:0]),
        .flags_in   (flags_reg),
        .hold_in    (hold_reg),
        .gap_in     (gap_reg),
        .count_in   (count_reg),
        .hold_limit (hold_limit_reg),
        .gap_limit  (gap_limit_reg),
        .ceiling    (ceiling),
        .flags_out  (flags_next),
        .hold_out   (hold_next),
        .gap_out    (gap_next),
        .count_out  (count_next),
        .result     (result)
    );

    bcc_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_word   (result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (out_word)
    );

    assign m_axis_tdata = OUT_DATA_BITS'(out_word);

endmodule

`default_nettype wire

// ----- rtl/core/bcc_checker.sv -----
// ----------------------------------------------------------------------------
// Button click classifier: port checker
// Watches the core's stream ports; bound to the top level below.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "button_click_classifier_core_defines.svh"

module bcc_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_axis_tready,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [bcc_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);
    import bcc_pkg::*;

    // stalled word stays put
    `BCC_ASSERT(a_hold_valid, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "m_axis_tvalid dropped under stall")
    `BCC_ASSERT(a_hold_data, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "m_axis_tdata changed under stall")
    // input only backs off when both buffer slots are full
    `BCC_ASSERT_ALWAYS(a_ready_full, !s_axis_tready |-> m_axis_tvalid, "s_axis_tready low with empty output")
    // count is 1 except for multi-click, never zero
    `BCC_ASSERT(a_count, m_axis_tvalid |-> (m_axis_tdata[9:2] != 8'd0) && ((m_axis_tdata[1:0] == EV_MULTI) || (m_axis_tdata[9:2] == 8'd1)) && (m_axis_tdata[15:10] == 6'd0), "bad click_count or padding")

endmodule

bind button_click_classifier_core bcc_checker u_bcc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
